FILE: sv/rtmt_pkg.sv
// ----------------------------------------------------------------------------
// Range top-two maximum tree: shared types and helpers
// Widths, item formats, the per-level token formats and the top-two merge.
// ----------------------------------------------------------------------------
package rtmt_pkg;

  localparam int LEAF_COUNT  = 1024;
  localparam int POS_W       = $clog2(LEAF_COUNT);
  localparam int CNT_W       = POS_W + 1;
  localparam int LEVEL_COUNT = POS_W + 1;
  localparam int VAL_W       = 31;
  localparam int SUM_W       = VAL_W + 1;
  localparam int PAIR_W      = 2 * VAL_W;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [POS_W-1:0] low_position;
    logic [POS_W-1:0] high_position;
    logic [VAL_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] largest;
    logic [VAL_W-1:0] second_largest;
    logic [SUM_W-1:0] top_two_sum;
  } res_t;

  typedef struct packed {
    logic [VAL_W-1:0] top;
    logic [VAL_W-1:0] second;
  } pair_t;

  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] off;
  } node_t;

  typedef struct packed {
    logic                  vld;
    logic                  upd;
    logic [POS_W-1:0]      first_pos;
    logic [POS_W-1:0]      last_pos;
    logic [VAL_W-1:0]      val;
    node_t [1:0]           part;
    logic [1:0]            full_vld;
    logic [1:0][POS_W-1:0] full_off;
    pair_t                 acc;
  } down_t;

  typedef struct packed {
    logic  vld;
    pair_t cur;
    pair_t sib;
  } up_t;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
  } clr_t;

  function automatic pair_t merge_pair(pair_t a, pair_t b);
    pair_t r;
    if (a.top >= b.top) begin
      r.top    = a.top;
      r.second = (a.second > b.top) ? a.second : b.top;
    end else begin
      r.top    = b.top;
      r.second = (b.second > a.top) ? b.second : a.top;
    end
    return r;
  endfunction

endpackage

FILE: sv/range_top_two_max_tree.sv
// ----------------------------------------------------------------------------
// Range top-two maximum tree
// Segment tree of top-two pairs with point update and range query.
// ----------------------------------------------------------------------------
// The tree is a row of eleven level cells, each with its own RAM, and one
// item is worked on at a time. A query walks its two boundary paths down the
// row, through the stage and output registers of each level cell. An update
// walks down to its leaf and then writes each ancestor on the way back up.
// After reset and after every write of element_count the store is cleared in
// a pass over all 1024 addresses during which no item is accepted. A finished
// result may wait at the output while the next item is accepted.
module range_top_two_max_tree (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rtmt_pkg::CNT_W-1:0] element_count,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  rtmt_pkg::req_t             req_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output rtmt_pkg::res_t             res_data
);

  rtmt_pkg::down_t down_bus [rtmt_pkg::LEVEL_COUNT+1];
  rtmt_pkg::up_t   up_bus   [rtmt_pkg::LEVEL_COUNT+1];
  rtmt_pkg::down_t launch;
  rtmt_pkg::down_t launch_next;
  rtmt_pkg::node_t root;
  rtmt_pkg::res_t  result;
  rtmt_pkg::res_t  spare;
  rtmt_pkg::clr_t  clr;
  logic [rtmt_pkg::CNT_W-1:0] count;
  logic [rtmt_pkg::CNT_W-1:0] count_next;
  logic [rtmt_pkg::POS_W-1:0] cnt_last;
  logic [rtmt_pkg::POS_W-1:0] clr_addr;
  logic [2*rtmt_pkg::LEVEL_COUNT:0] tok_vld;
  logic clr_busy;
  logic busy;
  logic spare_vld;
  logic req_acc;
  logic cfg_acc;
  logic query_done;
  logic upd_done;
  logic launch_live;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign req_ready = !busy && !clr_busy && !spare_vld;
  assign req_acc   = req_valid && req_ready;
  assign cnt_last  = rtmt_pkg::POS_W'(count - rtmt_pkg::CNT_W'(1));

  always_comb begin
    if (element_count == '0) begin
      count_next = rtmt_pkg::CNT_W'(1);
    end else if (element_count > rtmt_pkg::CNT_W'(rtmt_pkg::LEAF_COUNT)) begin
      count_next = rtmt_pkg::CNT_W'(rtmt_pkg::LEAF_COUNT);
    end else begin
      count_next = element_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= rtmt_pkg::CNT_W'(rtmt_pkg::LEAF_COUNT);
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (cfg_acc) begin
      count    <= count_next;
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + rtmt_pkg::POS_W'(1);
      if (clr_addr == rtmt_pkg::POS_W'(rtmt_pkg::LEAF_COUNT - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign clr.en   = clr_busy;
  assign clr.addr = clr_addr;

  always_comb begin
    root.vld = 1'b1;
    root.lo  = '0;
    root.hi  = cnt_last;
    root.off = '0;
    launch_live           = 1'b0;
    launch_next           = '0;
    launch_next.first_pos = req_data.low_position;
    launch_next.last_pos  = req_data.high_position;
    launch_next.val       = req_data.new_value;
    if (req_data.req_type == rtmt_pkg::REQ_UPDATE) begin
      launch_next.upd     = 1'b1;
      launch_live         = ({1'b0, req_data.low_position} < count);
      launch_next.part[0] = root;
    end else begin
      launch_live = 1'b1;
      if (req_data.low_position <= req_data.high_position) begin
        if ((req_data.low_position == '0) && (req_data.high_position >= cnt_last)) begin
          launch_next.full_vld[0] = 1'b1;
        end else if (req_data.low_position <= cnt_last) begin
          launch_next.part[0] = root;
        end
      end
    end
    launch_next.vld = req_acc && launch_live;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch.vld <= 1'b0;
      busy       <= 1'b0;
    end else begin
      launch <= launch_next;
      if (launch_next.vld) begin
        busy <= 1'b1;
      end else if (query_done || upd_done) begin
        busy <= 1'b0;
      end
    end
  end

  assign down_bus[0]                     = launch;
  assign up_bus[rtmt_pkg::LEVEL_COUNT]   = '0;

  for (genvar g = 0; g < rtmt_pkg::LEVEL_COUNT; g++) begin : g_level
    rtmt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clr),
      .down_in (down_bus[g]),
      .down_out(down_bus[g+1]),
      .up_in   (up_bus[g+1]),
      .up_out  (up_bus[g])
    );
    assign tok_vld[g] = up_bus[g].vld;
  end

  for (genvar g = 0; g <= rtmt_pkg::LEVEL_COUNT; g++) begin : g_tok
    assign tok_vld[rtmt_pkg::LEVEL_COUNT+g] = down_bus[g].vld;
  end

  assign query_done = down_bus[rtmt_pkg::LEVEL_COUNT].vld;
  assign upd_done   = up_bus[0].vld;

  always_comb begin
    result.largest        = down_bus[rtmt_pkg::LEVEL_COUNT].acc.top;
    result.second_largest = down_bus[rtmt_pkg::LEVEL_COUNT].acc.second;
    result.top_two_sum    = {1'b0, down_bus[rtmt_pkg::LEVEL_COUNT].acc.top} +
                            {1'b0, down_bus[rtmt_pkg::LEVEL_COUNT].acc.second};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      spare_vld <= 1'b0;
    end else if (query_done) begin
      if (res_valid && !res_ready) begin
        spare     <= result;
        spare_vld <= 1'b1;
      end else begin
        res_data  <= result;
        res_valid <= 1'b1;
      end
    end else if (res_valid && res_ready) begin
      if (spare_vld) begin
        res_data  <= spare;
        spare_vld <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vld))
    else $error("More than one item token is in flight in the level cells.");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (query_done || upd_done) |-> busy)
    else $error("An item finished while the block was not busy.");

  a_spare: assert property (@(posedge clk) disable iff (rst)
    spare_vld |-> (res_valid && !busy))
    else $error("The spare result is held without a waiting output item.");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> (tok_vld == '0))
    else $error("An item can be accepted while another is still in the cells.");

endmodule

FILE: sv/rtmt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rtmt_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr0,
  output logic [WIDTH-1:0]  rd_data0,
  input  logic [ADDR_W-1:0] rd_addr1,
  output logic [WIDTH-1:0]  rd_data1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

FILE: sv/rtmt_cell.sv
// ----------------------------------------------------------------------------
// Tree level cell
// Holds the nodes of one tree level, reads covered nodes for a query on the
// way down, and writes the updated path node on the way back up.
// ----------------------------------------------------------------------------
module rtmt_cell (
  input  logic           clk,
  input  logic           rst,
  input  rtmt_pkg::clr_t  clr,
  input  rtmt_pkg::down_t down_in,
  output rtmt_pkg::down_t down_out,
  input  rtmt_pkg::up_t   up_in,
  output rtmt_pkg::up_t   up_out
);

  rtmt_pkg::down_t stage;
  rtmt_pkg::down_t down_next;
  rtmt_pkg::up_t   up_next;
  rtmt_pkg::pair_t rd_data0;
  rtmt_pkg::pair_t rd_data1;
  rtmt_pkg::pair_t rd0;
  rtmt_pkg::pair_t rd1;
  rtmt_pkg::pair_t acc_new;
  rtmt_pkg::pair_t merged;
  rtmt_pkg::pair_t leaf_pair;
  rtmt_pkg::pair_t sib;
  rtmt_pkg::pair_t wr_data;
  rtmt_pkg::node_t child [4];
  logic [rtmt_pkg::POS_W-1:0] path_off;
  logic [rtmt_pkg::POS_W-1:0] wr_addr;
  logic [rtmt_pkg::POS_W-1:0] mid [2];
  logic [rtmt_pkg::POS_W:0]   mid_sum [2];
  logic [3:0] c_full;
  logic [3:0] c_part;
  logic [1:0] n_part;
  logic [1:0] n_full;
  logic       leaf;
  logic       go_left;
  logic       leaf_write;
  logic       wr_en;

  rtmt_ram #(
    .WIDTH(rtmt_pkg::PAIR_W),
    .DEPTH(rtmt_pkg::LEAF_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr0(down_in.full_off[0]),
    .rd_data0(rd_data0),
    .rd_addr1(down_in.full_off[1]),
    .rd_data1(rd_data1)
  );

  assign leaf       = (stage.part[0].lo == stage.part[0].hi);
  assign leaf_write = stage.vld && stage.upd && leaf;
  assign leaf_pair  = '{top: stage.val, second: '0};
  assign merged     = rtmt_pkg::merge_pair(up_in.cur, up_in.sib);
  assign rd0        = stage.full_vld[0] ? rd_data0 : '0;
  assign rd1        = stage.full_vld[1] ? rd_data1 : '0;
  assign acc_new    = rtmt_pkg::merge_pair(stage.acc, rtmt_pkg::merge_pair(rd0, rd1));

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mid_sum[i] = {1'b0, stage.part[i].lo} + {1'b0, stage.part[i].hi};
      mid[i]     = mid_sum[i][rtmt_pkg::POS_W:1];
      child[2*i].vld   = stage.part[i].vld;
      child[2*i].lo    = stage.part[i].lo;
      child[2*i].hi    = mid[i];
      child[2*i].off   = {stage.part[i].off[rtmt_pkg::POS_W-2:0], 1'b0};
      child[2*i+1].vld = stage.part[i].vld;
      child[2*i+1].lo  = mid[i] + rtmt_pkg::POS_W'(1);
      child[2*i+1].hi  = stage.part[i].hi;
      child[2*i+1].off = {stage.part[i].off[rtmt_pkg::POS_W-2:0], 1'b1};
    end
    for (int k = 0; k < 4; k++) begin
      c_full[k] = child[k].vld && (stage.first_pos <= child[k].lo) &&
                  (stage.last_pos >= child[k].hi);
      c_part[k] = child[k].vld && !c_full[k] &&
                  !((stage.first_pos > child[k].hi) || (stage.last_pos < child[k].lo));
    end
  end

  assign go_left = (stage.first_pos <= mid[0]);

  always_comb begin
    down_next          = stage;
    down_next.part     = '0;
    down_next.full_vld = '0;
    down_next.full_off = '0;
    n_part             = '0;
    n_full             = '0;
    if (stage.upd) begin
      down_next.vld         = stage.vld && !leaf;
      down_next.part[0]     = go_left ? child[0] : child[1];
      down_next.full_vld[0] = 1'b1;
      down_next.full_off[0] = go_left ? child[1].off : child[0].off;
    end else begin
      down_next.acc = acc_new;
      for (int k = 0; k < 4; k++) begin
        if (c_part[k]) begin
          if (n_part == 2'd0) begin
            down_next.part[0] = child[k];
          end else begin
            down_next.part[1] = child[k];
          end
          n_part = n_part + 2'd1;
        end
        if (c_full[k]) begin
          if (n_full == 2'd0) begin
            down_next.full_vld[0] = 1'b1;
            down_next.full_off[0] = child[k].off;
          end else begin
            down_next.full_vld[1] = 1'b1;
            down_next.full_off[1] = child[k].off;
          end
          n_full = n_full + 2'd1;
        end
      end
    end
  end

  always_comb begin
    up_next.vld = up_in.vld || leaf_write;
    up_next.cur = up_in.vld ? merged : leaf_pair;
    up_next.sib = up_in.vld ? sib : rd_data0;
  end

  always_comb begin
    wr_en = clr.en || up_in.vld || leaf_write;
    if (clr.en) begin
      wr_addr = clr.addr;
      wr_data = '0;
    end else if (up_in.vld) begin
      wr_addr = path_off;
      wr_data = merged;
    end else begin
      wr_addr = stage.part[0].off;
      wr_data = leaf_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.vld    <= 1'b0;
      down_out.vld <= 1'b0;
      up_out.vld   <= 1'b0;
    end else begin
      stage    <= down_in;
      down_out <= down_next;
      up_out   <= up_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.vld && stage.upd) begin
      sib      <= rd_data0;
      path_off <= stage.part[0].off;
    end
  end

endmodule
